// ===== hdl/lfo_pkg.sv =====
// Shared types, register and waveform codes, and table builders for the LFO.
package lfo_pkg;

	// Defaults for the top-level parameters.
	localparam int TABLE_DEPTH_DEF = 256;
	localparam int PHASE_BITS_DEF  = 32;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM_SELECT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQ_HZ      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_PER_HZ = 2'd3;

	// Waveform codes.
	localparam logic [2:0] WAVE_COSINE   = 3'd0;
	localparam logic [2:0] WAVE_RAMP     = 3'd1;
	localparam logic [2:0] WAVE_SAW      = 3'd2;
	localparam logic [2:0] WAVE_SQUARE   = 3'd3;
	localparam logic [2:0] WAVE_TAN_SINE = 3'd4;

	// Fixed-point constants.
	localparam logic [31:0] STEP_RESET  = 32'd89478;
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [15:0] WAVE_ONE    = 16'd16384;

	// Configuration register set as seen by the datapath.
	typedef struct packed {
		logic [2:0]  waveform_select;
		logic [31:0] base_freq_hz;
		logic [15:0] amplitude;
		logic [31:0] phase_step_per_hz;
	} cfg_t;

	// Restoring long division, used only while the tables are elaborated.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Alternating Taylor series in Q30; each term is the last times a^2/(n(n+1)).
	function automatic logic [63:0] series_q30(input logic [63:0] a, input logic [63:0] start,
			input int first);
		logic [63:0] term;
		logic [63:0] d;
		longint      sum;
		term = start;
		sum  = $signed(start);
		for (int i = 0; i < 7; i++) begin
			d    = 64'((first + 2 * i) * (first + 2 * i + 1));
			term = (term * a) >> 30;
			term = udiv64((term * a) >> 30, d);
			if (i % 2 == 1) begin
				sum = sum + $signed(term);
			end else begin
				sum = sum - $signed(term);
			end
		end
		return (sum < 0) ? 64'd0 : 64'(sum);
	endfunction

	// One quarter-wave entry: sine in Q2.14, or 0.65*tan(sin) in Q2.14.
	function automatic logic [15:0] rom_entry(input int k, input int depth, input logic shape);
		logic [63:0] ang;
		logic [63:0] s;
		logic [63:0] ts;
		logic [63:0] tc;
		logic [63:0] t;
		logic [63:0] v;
		ang = udiv64(64'(k) * HALF_PI_Q30, 64'(depth));
		s   = series_q30(ang, ang, 2);
		ts  = series_q30(s, s, 2);
		tc  = series_q30(s, Q30_ONE, 1);
		if (tc == 64'd0) begin
			tc = 64'd1;
		end
		t = udiv64(ts << 30, tc);
		if (shape) begin
			v = udiv64(t * 64'd13 + 64'd655360, 64'd1310720);
		end else begin
			v = (s + 64'd32768) >> 16;
		end
		return v[15:0];
	endfunction

endpackage

// ===== hdl/lfo_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
module lfo_mul
	import lfo_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	// The product of this cycle's operands is ready in the next cycle.
	// While the enable is low the last product is held.
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= 64'(a) * 64'(b);
		end
	end

	assign p = p_q;

endmodule

// ===== hdl/lfo_rom.sv =====
// Quarter-wave sine and tan-of-sine tables, built at elaboration.
module lfo_rom
	import lfo_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                               shape_sel,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]   idx,
	output logic [15:0]                        value
);

	logic [15:0] sin_tab   [TABLE_DEPTH+1];
	logic [15:0] shape_tab [TABLE_DEPTH+1];

	// Each entry is a constant worked out from the integer series.
	for (genvar k = 0; k <= TABLE_DEPTH; k++) begin : g_entry
		localparam logic [15:0] SIN_V   = rom_entry(k, TABLE_DEPTH, 1'b0);
		localparam logic [15:0] SHAPE_V = rom_entry(k, TABLE_DEPTH, 1'b1);
		assign sin_tab[k]   = SIN_V;
		assign shape_tab[k] = SHAPE_V;
	end

	// One read per item, from the table that the waveform needs.
	assign value = shape_sel ? shape_tab[idx] : sin_tab[idx];

endmodule

// ===== hdl/lfo_core.sv =====
// Sequencer and datapath: phase accumulator, waveform and gain around one multiplier.
module lfo_core
	import lfo_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        start,
	input  logic [31:0] fm_hz,
	input  logic [15:0] am_level,
	input  logic        am_connected,
	input  logic        out_free,
	output logic        idle,
	output logic        done,
	output logic [31:0] sample
);

	localparam int IDX_W = $clog2(TABLE_DEPTH + 1);
	localparam int SHIFT = 32 - PHASE_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_PHASE,
		ST_SETUP,
		ST_WAVE,
		ST_AMP,
		ST_AM,
		ST_OUT
	} state_t;

	state_t                state_q;
	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [31:0]           freq_q;
	logic [15:0]           am_mag_q;
	logic                  am_neg_q;
	logic [1:0]            quad_q;
	logic [15:0]           wave_mag_q;
	logic                  wave_neg_q;

	logic             mul_en;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [63:0]      mul_p;
	logic [31:0]      fm_mag;
	logic [32:0]      freq_sum;
	logic [31:0]      freq_sat;
	logic [15:0]      am_abs;
	logic [31:0]      p32;
	logic [31:0]      phase_mag;
	logic [31:0]      u_look;
	logic [IDX_W-1:0] tab_raw;
	logic [IDX_W-1:0] tab_idx;
	logic [15:0]      rom_val;
	logic [63:0]      ramp_sum;
	logic [15:0]      wave_mag_d;
	logic             wave_neg_d;
	logic [47:0]      out_rnd;
	logic [27:0]      out_mag;
	logic             is_ramp;

	// The final product must stay put while the result waits for the output register.
	assign mul_en = (state_q != ST_OUT);

	lfo_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	lfo_rom #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_rom (
		.shape_sel (cfg.waveform_select == WAVE_TAN_SINE),
		.idx       (tab_idx),
		.value     (rom_val)
	);

	// Input conditioning: |fm| plus base frequency saturates; AM magnitude and sign.
	always_comb begin
		fm_mag   = fm_hz[31] ? (~fm_hz + 32'd1) : fm_hz;
		freq_sum = {1'b0, cfg.base_freq_hz} + {1'b0, fm_mag};
		freq_sat = freq_sum[32] ? '1 : freq_sum[31:0];
		am_abs   = am_level[15] ? (~am_level + 16'd1) : am_level;
	end

	// Phase seen as a full 32-bit turn, its magnitude, and the table lookup angle.
	always_comb begin
		p32       = 32'(phase_acc_q) << SHIFT;
		phase_mag = p32[31] ? (~p32 + 32'd1) : p32;
		u_look    = (cfg.waveform_select == WAVE_COSINE) ? (p32 + 32'h4000_0000) : p32;
		is_ramp   = (cfg.waveform_select == WAVE_RAMP) || (cfg.waveform_select == WAVE_SAW);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_INC: begin
				mul_a = freq_q;
				mul_b = cfg.phase_step_per_hz;
			end
			ST_SETUP: begin
				if (is_ramp) begin
					mul_a = phase_mag;
					mul_b = PI_Q30;
				end else begin
					mul_a = {2'b00, u_look[29:0]};
					mul_b = 32'(TABLE_DEPTH);
				end
			end
			ST_AMP: begin
				mul_a = {16'd0, wave_mag_q};
				mul_b = {16'd0, cfg.amplitude};
			end
			ST_AM: begin
				mul_a = mul_p[31:0];
				mul_b = {16'd0, am_mag_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Waveform from the phase: table lookup, rounded ramp, square, or silence for unused codes.
	always_comb begin
		tab_raw  = mul_p[30 +: IDX_W];
		tab_idx  = quad_q[0] ? (IDX_W'(TABLE_DEPTH) - tab_raw) : tab_raw;
		ramp_sum = mul_p + 64'h0000_8000_0000_0000;
		case (cfg.waveform_select)
			WAVE_COSINE, WAVE_TAN_SINE: begin
				wave_mag_d = rom_val;
				wave_neg_d = quad_q[1];
			end
			WAVE_RAMP, WAVE_SAW: begin
				wave_mag_d = ramp_sum[63:48];
				wave_neg_d = p32[31] ^ (cfg.waveform_select == WAVE_SAW);
			end
			WAVE_SQUARE: begin
				wave_mag_d = (!p32[31] && (p32 != 32'd0)) ? WAVE_ONE : 16'd0;
				wave_neg_d = 1'b0;
			end
			default: begin
				wave_mag_d = 16'd0;
				wave_neg_d = 1'b0;
			end
		endcase
	end

	// Rounding of the Q16.16 result, ties away from zero. The magnitude stays
	// below 2^27, so the signed result never reaches its limits.
	always_comb begin
		out_rnd = mul_p[47:0] + 48'd524288;
		out_mag = out_rnd[47:20];
		sample  = (wave_neg_q ^ am_neg_q) ? (32'd0 - 32'(out_mag)) : 32'(out_mag);
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_OUT) && out_free;

	// Sequencer with its working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_acc_q <= '0;
			freq_q      <= '0;
			am_mag_q    <= '0;
			am_neg_q    <= 1'b0;
			quad_q      <= '0;
			wave_mag_q  <= '0;
			wave_neg_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						freq_q   <= freq_sat;
						am_mag_q <= am_connected ? am_abs : WAVE_ONE;
						am_neg_q <= am_connected && am_level[15];
						state_q  <= ST_INC;
					end
				end
				ST_INC: begin
					state_q <= ST_PHASE;
				end
				ST_PHASE: begin
					phase_acc_q <= phase_acc_q + PHASE_BITS'(mul_p[47:16] >> SHIFT);
					state_q     <= ST_SETUP;
				end
				ST_SETUP: begin
					quad_q  <= u_look[31:30];
					state_q <= ST_WAVE;
				end
				ST_WAVE: begin
					wave_mag_q <= wave_mag_d;
					wave_neg_q <= wave_neg_d;
					state_q    <= ST_AMP;
				end
				ST_AMP: begin
					state_q <= ST_AM;
				end
				ST_AM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/lfo_waveform_generator.sv =====
// Top level of the LFO: configuration registers, stream ports and output register.
// An input transfer is taken when the sequencer is idle; it then runs INC, PHASE,
// SETUP, WAVE, AMP, AM and OUT, and the result enters the output register as it
// leaves OUT. The next transfer can be taken only in the cycle after that; the
// shared multiplier serves four products per item. A stalled output holds the
// sequencer in OUT. Reset restores the register defaults and clears the phase.
module lfo_waveform_generator
	import lfo_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration writes.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,  // fm_hz[31:0], am_level[47:32]
	input  logic                  s_tuser,  // am_connected
	// Output stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata   // sample[31:0]
);

	cfg_t        cfg_q;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        core_idle;
	logic        core_done;
	logic [31:0] core_sample;
	logic        out_free;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.waveform_select   <= WAVE_COSINE;
			cfg_q.base_freq_hz      <= '0;
			cfg_q.amplitude         <= '0;
			cfg_q.phase_step_per_hz <= STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVEFORM_SELECT:   cfg_q.waveform_select   <= cfg_wdata[2:0];
				REG_BASE_FREQ_HZ:      cfg_q.base_freq_hz      <= cfg_wdata[31:0];
				REG_AMPLITUDE:         cfg_q.amplitude         <= cfg_wdata[15:0];
				REG_PHASE_STEP_PER_HZ: cfg_q.phase_step_per_hz <= cfg_wdata[31:0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready = core_idle;
	assign out_free = !m_tvalid_q || m_tready;

	lfo_core #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PHASE_BITS  (PHASE_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (s_tvalid && core_idle),
		.fm_hz        (s_tdata[31:0]),
		.am_level     (s_tdata[47:32]),
		.am_connected (s_tuser),
		.out_free     (out_free),
		.idle         (core_idle),
		.done         (core_done),
		.sample       (core_sample)
	);

	// Output register; it frees as soon as its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (core_done) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= core_sample;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the LFO waveform generator with a bit-exact scoreboard.
module testbench;
	import lfo_pkg::*;

	localparam int ROM_DEPTH     = TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 75;

	// Scoreboard: carries its own oscillator state and the queue of predicted samples.
	class lfo_scoreboard;
		logic [2:0]  wave_sel;
		logic [31:0] base_freq;
		logic [15:0] gain;
		logic [31:0] step_per_hz;
		logic [31:0] phase;
		logic [15:0] sine_quarter [0:ROM_DEPTH];
		logic [15:0] shape_quarter [0:ROM_DEPTH];
		logic [31:0] expected_samples [$];
		int          failures;

		function new();
			logic [63:0] ang;
			logic [63:0] s;
			logic [63:0] ts;
			logic [63:0] tc;
			logic [63:0] t;
			// Quarter-wave tables of sine and of 0.65*tan(sin), both in Q2.14.
			for (int k = 0; k <= ROM_DEPTH; k++) begin
				ang = (64'(k) * HALF_PI_Q30) / 64'(ROM_DEPTH);
				s   = taylor_alt(ang, ang, 2);
				ts  = taylor_alt(s, s, 2);
				tc  = taylor_alt(s, Q30_ONE, 1);
				if (tc == 64'd0) begin
					tc = 64'd1;
				end
				t = (ts << 30) / tc;
				sine_quarter[k]  = 16'((s + 64'd32768) >> 16);
				shape_quarter[k] = 16'((t * 64'd13 + 64'd655360) / 64'd1310720);
			end
			wave_sel    = WAVE_COSINE;
			base_freq   = '0;
			gain        = '0;
			step_per_hz = STEP_RESET;
			phase       = '0;
			failures    = 0;
		endfunction

		// Series in Q30, start plus seven alternating terms; each is the last one times a^2/(n(n+1)).
		function logic [63:0] taylor_alt(logic [63:0] a, logic [63:0] start, int first);
			logic [63:0] term;
			logic [63:0] div;
			longint      acc;
			term = start;
			acc  = $signed(start);
			for (int i = 0; i < 7; i++) begin
				div  = 64'((first + 2 * i) * (first + 2 * i + 1));
				term = (term * a) >> 30;
				term = ((term * a) >> 30) / div;
				if (i % 2 == 1) begin
					acc = acc + $signed(term);
				end else begin
					acc = acc - $signed(term);
				end
			end
			return (acc < 0) ? 64'd0 : 64'(acc);
		endfunction

		// Odd, quarter-symmetric table read against a full-turn phase.
		function longint quarter_read(bit use_shape, logic [31:0] u);
			logic [63:0] idx;
			int          pos;
			longint      v;
			idx = (64'(u[29:0]) * 64'(ROM_DEPTH)) >> 30;
			pos = u[30] ? ROM_DEPTH - int'(idx) : int'(idx);
			v   = use_shape ? longint'(shape_quarter[pos]) : longint'(sine_quarter[pos]);
			return u[31] ? -v : v;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				REG_WAVEFORM_SELECT:   wave_sel    = value[2:0];
				REG_BASE_FREQ_HZ:      base_freq   = value;
				REG_AMPLITUDE:         gain        = value[15:0];
				REG_PHASE_STEP_PER_HZ: step_per_hz = value;
				default: ;
			endcase
		endfunction

		// Advances the phase for one accepted input transfer and predicts its sample.
		function void note_input(logic [31:0] fm, logic [15:0] am, logic am_on);
			logic [31:0] fm_mag;
			logic [32:0] freq_sum;
			logic [31:0] freq;
			logic [63:0] inc_full;
			logic [63:0] mag;
			logic [63:0] prod;
			logic [31:0] sample;
			longint      wave;
			longint      am_val;
			bit          neg;

			fm_mag   = fm[31] ? ~fm + 32'd1 : fm;
			freq_sum = {1'b0, base_freq} + {1'b0, fm_mag};
			freq     = freq_sum[32] ? 32'hFFFF_FFFF : freq_sum[31:0];
			inc_full = {32'd0, freq} * {32'd0, step_per_hz};
			phase    = phase + inc_full[47:16];

			case (wave_sel)
				WAVE_COSINE: wave = quarter_read(1'b0, phase + 32'h4000_0000);
				WAVE_RAMP, WAVE_SAW: begin
					mag  = phase[31] ? {32'd0, ~phase} + 64'd1 : {32'd0, phase};
					wave = longint'((mag * {32'd0, PI_Q30} + (64'd1 << 47)) >> 48);
					if (phase[31] != (wave_sel == WAVE_SAW)) begin
						wave = -wave;
					end
				end
				WAVE_SQUARE: wave = (!phase[31] && phase != 32'd0) ? longint'(WAVE_ONE) : 0;
				WAVE_TAN_SINE: wave = quarter_read(1'b1, phase);
				default: wave = 0;
			endcase

			// Scale by gain and AM, round half away from zero, then saturate.
			am_val = am_on ? longint'($signed(am)) : longint'(WAVE_ONE);
			neg    = (wave < 0) != (am_val < 0);
			prod   = 64'(wave < 0 ? -wave : wave) * 64'(gain)
				* 64'(am_val < 0 ? -am_val : am_val);
			prod   = (prod + (64'd1 << 19)) >> 20;
			if (neg && prod > 64'h8000_0000) begin
				prod = 64'h8000_0000;
			end else if (!neg && prod > 64'h7FFF_FFFF) begin
				prod = 64'h7FFF_FFFF;
			end
			sample = prod[31:0];
			if (neg) begin
				sample = -sample;
			end
			expected_samples.push_back(sample);
		endfunction

		function void check_sample(logic [31:0] got);
			logic [31:0] want;
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample: expected none, actual %h", $time, got);
				failures++;
			end else begin
				want = expected_samples.pop_front();
				if (want !== got) begin
					$display("%0t: sample mismatch: expected %h, actual %h", $time, want, got);
					failures++;
				end
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata   = '0;  // fm_hz[31:0], am_level[47:32]
	logic                  s_tuser   = 1'b0;  // am_connected
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [31:0]           m_tdata;  // sample[31:0]

	lfo_scoreboard scoreboard = new();
	int            cycle_count = 0;
	bit            sender_steady = 1'b0;

	lfo_waveform_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Every output transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			scoreboard.check_sample(m_tdata);
		end
	end

	// Idle lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [31:0] random_fm();
		logic [31:0] fm;
		int          r;
		r = $urandom_range(99);
		if (r < 45) begin
			fm = $urandom_range(32'h0010_0000);
		end else if (r < 90) begin
			fm = $urandom();
		end else begin
			fm = ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h0000_0001;
		end
		if ($urandom_range(1) != 0) begin
			fm = -fm;
		end
		return fm;
	endfunction

	// Output side: ready stretches of random length broken by random stalls.
	initial begin : output_side
		int run;
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run   = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(200, 50);
			stall = pick_gap();
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// One input transfer, preceded by a random idle gap unless the sender is steady.
	task automatic send_item(input logic [31:0] fm, input logic [15:0] am, input logic am_on);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {am, fm};
		s_tuser  <= am_on;
		do @(posedge clk); while (!s_tready);
		scoreboard.note_input(fm, am, am_on);
	endtask

	// Stops the sender and waits until every predicted sample has come out.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (scoreboard.pending() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		scoreboard.set_register(idx, value);
	endtask

	// Unused upper bits of the narrow registers carry random junk.
	task automatic configure(input logic [2:0] sel, input logic [31:0] base,
			input logic [15:0] amp, input logic [31:0] step);
		write_reg(REG_WAVEFORM_SELECT, {29'($urandom()), sel});
		write_reg(REG_BASE_FREQ_HZ, base);
		write_reg(REG_AMPLITUDE, {16'($urandom()), amp});
		write_reg(REG_PHASE_STEP_PER_HZ, step);
	endtask

	initial begin : stimulus
		logic [2:0]  sel;
		logic [31:0] base;
		logic [15:0] amp;
		logic [31:0] step;
		int          r;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults straight after reset: zero gain gives silence.
		send_item(32'd0, 16'h4000, 1'b1);
		quiesce();

		// Ramp with half-turn steps at the negative half turn and zero phase, then a negative quarter turn.
		configure(WAVE_RAMP, 32'h0001_0000, 16'hFFFF, 32'h8000_0000);
		send_item(32'd0, 16'h0000, 1'b0);
		send_item(32'd0, 16'h7FFF, 1'b1);
		send_item(32'h0000_8000, 16'h8000, 1'b1);
		quiesce();

		// Saw reaching the negative half turn on its last item.
		configure(WAVE_SAW, 32'h0001_0000, 16'hFFFF, 32'h8000_0000);
		send_item(32'd0, 16'h4000, 1'b1);
		send_item(32'd0, 16'hC000, 1'b1);
		send_item(32'h0000_8000, 16'h7FFF, 1'b1);
		quiesce();

		// Square at exactly zero phase, negative phases and a positive one.
		configure(WAVE_SQUARE, 32'h0001_0000, 16'hFFFF, 32'h8000_0000);
		send_item(32'd0, 16'h7FFF, 1'b1);
		send_item(32'h0000_8000, 16'h8000, 1'b1);
		send_item(32'h0000_8000, 16'h4000, 1'b0);
		send_item(32'h0000_8000, 16'h8000, 1'b1);
		quiesce();

		// Cosine with a saturating frequency sum and full-scale step.
		configure(WAVE_COSINE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(32'h7FFF_FFFF, 16'h7FFF, 1'b1);
		send_item(32'h8000_0000, 16'h8000, 1'b1);
		send_item(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		quiesce();

		// Tan-of-sine shape stepped through quarter turns and finer steps.
		configure(WAVE_TAN_SINE, 32'd0, 16'h0100, 32'h4000_0000);
		send_item(32'h0001_0000, 16'h4000, 1'b1);
		send_item(32'hFFFF_0000, 16'h2000, 1'b1);
		send_item(32'h0000_1000, 16'hE000, 1'b1);
		send_item(32'd0, 16'h0000, 1'b0);
		quiesce();

		// Unused selectors give silence while the phase still moves.
		configure(3'd5, $urandom(), 16'hFFFF, STEP_RESET);
		send_item(random_fm(), 16'($urandom()), 1'b1);
		quiesce();
		configure(3'd7, $urandom(), 16'hFFFF, STEP_RESET);
		send_item(random_fm(), 16'($urandom()), 1'b0);
		quiesce();
		configure(3'd6, $urandom(), 16'h0000, $urandom());
		send_item(random_fm(), 16'($urandom()), 1'b1);
		quiesce();

		// Zero step per hertz freezes the phase.
		configure(WAVE_COSINE, 32'h1234_5678, 16'h8000, 32'd0);
		send_item(random_fm(), 16'($urandom()), 1'b1);
		send_item(random_fm(), 16'($urandom()), 1'b1);
		quiesce();

		// Random phases, each with its own register setting.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			sel = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
			r = $urandom_range(3);
			base = (r == 0) ? 32'd0 : (r == 1) ? 32'($urandom_range(32'h0100_0000))
				: (r == 2) ? 32'hFFFF_FFFF : $urandom();
			r = $urandom_range(3);
			amp = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0100 : 16'($urandom());
			r = $urandom_range(3);
			step = (r == 0) ? STEP_RESET : (r == 1) ? 32'hFFFF_FFFF
				: (r == 2) ? 32'($urandom_range(32'h0010_0000)) : $urandom();
			configure(sel, base, amp, step);
			sender_steady = ($urandom_range(3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_item(random_fm(), 16'($urandom()), 1'($urandom_range(1)));
			end
			quiesce();
		end

		if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
